@@ hdl/mf8_pkg.sv @@
// Package for the minifloat multiplier with ring store.
// Holds the ring geometry and the minifloat multiply function; no dependencies.
`default_nettype none
package mf8_pkg;
  localparam int RING_DEPTH = 16;
  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ENTRY_W = 24;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  function automatic logic [7:0] fp8_mul(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] ea;
    logic [4:0] eb;
    logic       sign;
    logic [5:0] p;
    logic       carry;
    logic [1:0] man;
    logic [6:0] x;
    logic [7:0] res;
    ea = a[6:2];
    eb = b[6:2];
    sign = a[7] ^ b[7];
    p = {3'b001, a[1:0]} * {3'b001, b[1:0]};
    carry = p[5];
    man = carry ? p[4:3] : p[3:2];
    x = {2'b00, ea} + {2'b00, eb} + {6'b0, carry};
    if (ea == 5'd0 || eb == 5'd0 || x < 7'd15) begin
      res = 8'h00;
    end else if (x > 7'd46) begin
      res = {sign, 5'd31, man};
    end else begin
      res = {sign, 5'(x - 7'd15), man};
    end
    return res;
  endfunction
endpackage
`default_nettype wire

@@ hdl/minifloat8_multiply_delay.sv @@
// Top level: fp8 (e5m2) truncating multiplier feeding a ring store.
// Depends on mf8_pkg for ring geometry and the multiply function.
// Each accepted item writes its product and operands into the ring; with take set,
// the entry at the read pointer is emitted. One item per cycle unless the output
// stalls; a result appears next cycle (synchronous memory read), held in an output
// register. Same-entry write/read in one cycle is forwarded from the incoming item.
`default_nettype none
module minifloat8_multiply_delay (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] operand_a,
  input  wire logic [7:0] operand_b,
  input  wire logic       take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      product,
  output logic [7:0]      echo_a,
  output logic [7:0]      echo_b
);
  mf8_pkg::entry_t ring [mf8_pkg::RING_DEPTH];
  logic [mf8_pkg::RING_DEPTH-1:0] written;
  mf8_pkg::ptr_t write_ptr;
  mf8_pkg::ptr_t read_ptr;
  mf8_pkg::entry_t rd_data;
  mf8_pkg::entry_t wr_data;
  mf8_pkg::entry_t fwd_data;
  logic fwd;
  logic rd_valid;
  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign wr_data = {mf8_pkg::fp8_mul(operand_a, operand_b), operand_a, operand_b};

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_ptr] <= wr_data;
    end
    rd_data <= ring[read_ptr];
    fwd_data <= wr_data;
    fwd <= (write_ptr == read_ptr);
    rd_valid <= written[read_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr <= '0;
      written <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept && take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        written[write_ptr] <= 1'b1;
        write_ptr <= (write_ptr == mf8_pkg::ptr_t'(mf8_pkg::RING_DEPTH - 1)) ?
                     '0 : write_ptr + 1'b1;
        if (take) begin
          read_ptr <= (read_ptr == mf8_pkg::ptr_t'(mf8_pkg::RING_DEPTH - 1)) ?
                      '0 : read_ptr + 1'b1;
        end
      end
    end
  end

  // select forwarded, stored, or reset value for the item
  mf8_pkg::entry_t sel;
  always_comb begin
    if (fwd) begin
      sel = fwd_data;
    end else if (rd_valid) begin
      sel = rd_data;
    end else begin
      sel = '0;
    end
  end

  logic [23:0] hold;
  logic        first;
  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b0;
    end else begin
      first <= accept && take;
    end
    if (first) begin
      hold <= sel;
    end
  end

  always_comb begin
    if (first) begin
      {product, echo_a, echo_b} = sel;
    end else begin
      {product, echo_a, echo_b} = hold;
    end
  end
endmodule
`default_nettype wire
